/* rtl/core/xrst_pkg.sv */
`timescale 1ns / 1ps
// shared constants and types for the xor remapped range sum tree
// no dependencies
package xrst_pkg;

   localparam int LOG_SIZE   = 10;
   localparam int VALUE_BITS = 30;
   localparam int SUM_W      = 40;
   localparam int NODE_W     = LOG_SIZE + 1;
   localparam int PTR_W      = LOG_SIZE + 2;
   localparam int MEM_DEPTH  = 1 << NODE_W;
   localparam int MODE_W     = 2;
   localparam int INDEX_W    = 10;
   localparam int VALUE_W    = 30;
   localparam int LEVEL_W    = 4;

   localparam logic [MODE_W-1:0] MODE_SET   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REV   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SWAP  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_QUERY = 2'd3;

   typedef struct packed {
      logic              wr_en;
      logic [NODE_W-1:0] wr_addr;
      logic [SUM_W-1:0]  wr_data;
      logic              rd_en;
      logic [NODE_W-1:0] rd_addr;
   } mem_req_type;

endpackage

/* rtl/core/xrst_if.sv */
`timescale 1ns / 1ps
// request and response channel interfaces
// depends on xrst_pkg
interface xrst_req_if;
   logic                         valid;
   logic                         ready;
   logic [xrst_pkg::MODE_W-1:0]  mode;
   logic [xrst_pkg::INDEX_W-1:0] index;
   logic [xrst_pkg::VALUE_W-1:0] value;
   logic [xrst_pkg::LEVEL_W-1:0] level;
   logic [xrst_pkg::INDEX_W-1:0] range_low;
   logic [xrst_pkg::INDEX_W-1:0] range_high;
   modport source(output valid, mode, index, value, level, range_low, range_high,
                  input ready);
   modport sink(input valid, mode, index, value, level, range_low, range_high,
                output ready);
endinterface

interface xrst_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [xrst_pkg::SUM_W-1:0] sum;
   modport source(output valid, sum, input ready);
   modport sink(input valid, sum, output ready);
endinterface

/* rtl/core/xrst_store.sv */
`timescale 1ns / 1ps
// node sum memory, one write and one registered read per cycle
// depends on xrst_pkg
module xrst_store (
   input  logic                       clock,
   input  xrst_pkg::mem_req_type      mem_req,
   output logic [xrst_pkg::SUM_W-1:0] rd_data
);

   logic [xrst_pkg::SUM_W-1:0] mem [xrst_pkg::MEM_DEPTH];

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data <= mem[mem_req.rd_addr];
      end
   end

endmodule

/* rtl/core/xrst_seq.sv */
`timescale 1ns / 1ps
// sequencer: clearing pass, leaf update walk, range query walk, index mask
// depends on xrst_pkg, xrst_if
module xrst_seq (
   input  logic                       clock,
   input  logic                       reset,
   xrst_req_if.sink                   req_chan,
   input  logic                       out_free,
   output logic                       fin,
   output logic [xrst_pkg::SUM_W-1:0] fin_sum,
   output xrst_pkg::mem_req_type      mem_req,
   input  logic [xrst_pkg::SUM_W-1:0] rd_data
);

   localparam logic [2:0] ST_CLR  = 3'd0;
   localparam logic [2:0] ST_IDLE = 3'd1;
   localparam logic [2:0] ST_UWR  = 3'd2;
   localparam logic [2:0] ST_UADD = 3'd3;
   localparam logic [2:0] ST_QL   = 3'd4;
   localparam logic [2:0] ST_QR   = 3'd5;
   localparam logic [2:0] ST_QFIN = 3'd6;

   localparam int LS = xrst_pkg::LOG_SIZE;
   localparam int NW = xrst_pkg::NODE_W;
   localparam int PW = xrst_pkg::PTR_W;
   localparam int SW = xrst_pkg::SUM_W;

   logic [2:0]    state_ff, state_in;
   logic [NW-1:0] clr_ff, clr_in;
   logic [LS-1:0] mask_ff, mask_in;
   logic [LS-1:0] qmask_ff, qmask_in;
   logic [NW-1:0] node_ff, node_in;
   logic [SW-1:0] acc_ff, acc_in;
   logic [PW-1:0] lp_ff, lp_in;
   logic [PW-1:0] rp_ff, rp_in;
   logic          pend_ff, pend_in;
   logic [LS-1:0] rev_bits, swap_bits;
   logic [LS-1:0] idx, lo, hi;
   logic [PW-1:0] rp_dec;
   logic          accept;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept  = req_chan.valid && req_chan.ready;
   assign idx     = req_chan.index[LS-1:0];
   assign lo      = req_chan.range_low[LS-1:0];
   assign hi      = req_chan.range_high[LS-1:0];
   assign rp_dec  = rp_ff - PW'(1);
   assign fin_sum = acc_ff;

   always_comb begin
      for (int i = 0; i < LS; i++) begin
         rev_bits[i]  = 32'(req_chan.level) > i;
         swap_bits[i] = 32'(req_chan.level) == i;
      end
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      mask_in  = mask_ff;
      qmask_in = qmask_ff;
      node_in  = node_ff;
      acc_in   = acc_ff;
      lp_in    = lp_ff;
      rp_in    = rp_ff;
      pend_in  = 1'b0;
      fin      = 1'b0;
      mem_req  = '0;
      case (state_ff)
         ST_CLR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = clr_ff;
            clr_in          = clr_ff + NW'(1);
            if (clr_ff == NW'(xrst_pkg::MEM_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_chan.mode)
                  xrst_pkg::MODE_SET: begin
                     node_in  = {1'b1, idx ^ mask_ff};
                     acc_in   = SW'(req_chan.value[xrst_pkg::VALUE_BITS-1:0]);
                     state_in = ST_UWR;
                  end
                  xrst_pkg::MODE_REV: begin
                     mask_in = mask_ff ^ rev_bits;
                  end
                  xrst_pkg::MODE_SWAP: begin
                     mask_in = mask_ff ^ swap_bits;
                  end
                  default: begin
                     acc_in   = '0;
                     qmask_in = mask_ff;
                     lp_in    = PW'({1'b1, lo});
                     rp_in    = PW'({1'b1, hi}) + PW'(1);
                     state_in = (lo > hi) ? ST_QFIN : ST_QL;
                  end
               endcase
            end
         end
         ST_UWR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = node_ff;
            mem_req.wr_data = acc_ff;
            if (node_ff == NW'(1)) begin
               state_in = ST_IDLE;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = node_ff ^ NW'(1);
               state_in        = ST_UADD;
            end
         end
         ST_UADD: begin
            acc_in   = acc_ff + rd_data;
            node_in  = node_ff >> 1;
            state_in = ST_UWR;
         end
         ST_QL: begin
            if (pend_ff) begin
               acc_in = acc_ff + rd_data;
            end
            if (lp_ff >= rp_ff) begin
               state_in = ST_QFIN;
            end else begin
               if (lp_ff[0]) begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = lp_ff[NW-1:0] ^ NW'(qmask_ff);
                  pend_in         = 1'b1;
                  lp_in           = lp_ff + PW'(1);
               end
               state_in = ST_QR;
            end
         end
         ST_QR: begin
            if (pend_ff) begin
               acc_in = acc_ff + rd_data;
            end
            if (rp_ff[0]) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = rp_dec[NW-1:0] ^ NW'(qmask_ff);
               pend_in         = 1'b1;
               rp_in           = rp_dec >> 1;
            end else begin
               rp_in = rp_ff >> 1;
            end
            lp_in    = lp_ff >> 1;
            qmask_in = qmask_ff >> 1;
            state_in = ST_QL;
         end
         ST_QFIN: begin
            if (out_free) begin
               fin      = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR;
         clr_ff   <= '0;
         mask_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         mask_ff  <= mask_in;
         pend_ff  <= pend_in;
      end
      qmask_ff <= qmask_in;
      node_ff  <= node_in;
      acc_ff   <= acc_in;
      lp_ff    <= lp_in;
      rp_ff    <= rp_in;
   end

endmodule

/* rtl/core/xor_remapped_range_sum_tree_top.sv */
`timescale 1ns / 1ps
// Range sum tree over 1024 values with an xor index mask. After reset the
// block sweeps its 2048-entry node memory to zero, one entry a cycle, and
// takes no request during the sweep. Reverse and swap requests change only
// the index mask. A set request writes the leaf and walks up to the root,
// writing each node while reading its sibling and then adding the sibling
// into the running sum. A range query makes up to two memory reads per level,
// plus any wait for the response register. One request is worked at a time.
// depends on xrst_pkg, xrst_if, xrst_store, xrst_seq
module xor_remapped_range_sum_tree_top (
   input logic         clock,
   input logic         reset,
   xrst_req_if.sink    req_chan,
   xrst_rsp_if.source  rsp_chan
);

   xrst_pkg::mem_req_type      mem_req;
   logic [xrst_pkg::SUM_W-1:0] rd_data;
   logic [xrst_pkg::SUM_W-1:0] fin_sum;
   logic [xrst_pkg::SUM_W-1:0] sum_ff;
   logic                       fin;
   logic                       out_free;
   logic                       rsp_valid_ff, rsp_valid_in;

   xrst_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   xrst_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .out_free (out_free),
      .fin      (fin),
      .fin_sum  (fin_sum),
      .mem_req  (mem_req),
      .rd_data  (rd_data)
   );

   assign out_free      = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_valid_in  = fin || (rsp_valid_ff && !rsp_chan.ready);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.sum   = sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (fin) begin
         sum_ff <= fin_sum;
      end
   end

   // clearing pass blocks requests right after reset
   a_clr_blocks: assert property (@(posedge clock) reset |=> !req_chan.ready)
      else $error("request accepted during clearing pass");

   // update walk never reads the node it writes
   a_no_rw_same: assert property (@(posedge clock) disable iff (reset)
      (mem_req.wr_en && mem_req.rd_en) |-> (mem_req.wr_addr != mem_req.rd_addr))
      else $error("read and write of same node");

   // a result is loaded only into a free response slot
   a_fin_free: assert property (@(posedge clock) disable iff (reset)
      fin |-> (!rsp_valid_ff || rsp_chan.ready))
      else $error("response overwritten");

   // no memory read is issued while the sequencer is idle and ready
   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> !mem_req.rd_en)
      else $error("memory read while idle");

endmodule
